FILE: src/elop_pkg.sv
// Shared types and constants for the ellipse outline point generator.
package elop_pkg;

  localparam int unsigned AXIS_W   = 10;
  localparam int unsigned CTR_W    = 15;
  localparam int unsigned IDX_W    = 12;
  localparam int unsigned COORD_W  = 24;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned SQ_W     = 2 * AXIS_W;              // a*a, x*x, b*b
  localparam int unsigned PROD_W   = 2 * SQ_W;                // b*b*(a*a-x*x)
  localparam int unsigned RAD_W    = PROD_W + 2 * FRAC_W;     // radicand
  localparam int unsigned ROOT_W   = RAD_W / 2;               // sqrt steps
  localparam int unsigned REM_W    = ROOT_W + 2;              // sqrt remainder
  localparam int unsigned Y_W      = AXIS_W + FRAC_W;         // height bound 256*b
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned QPTR_W   = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W   = QPTR_W + 1;
  localparam int unsigned CFG_IDX_W = 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AXIS_FIRST  = 3'd0,
    CFG_AXIS_SECOND = 3'd1,
    CFG_CENTER_X    = 3'd2,
    CFG_CENTER_Y    = 3'd3
  } cfg_idx_e;

  // Ring quadrant of an emitted point
  typedef enum logic [1:0] {
    PH_UR,
    PH_LR,
    PH_LL,
    PH_UL
  } phase_e;

  // One offset with its height, between front and back
  typedef struct packed {
    logic [AXIS_W-1:0] x;
    logic [Y_W-1:0]    y;
  } q_item_t;

endpackage

FILE: src/elop_front.sv
// Front: offset saturation, squares, pipelined square root and division.
module elop_front import elop_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [AXIS_W-1:0] in_x_i,
  input  logic [AXIS_W-1:0] semi_a_i,
  input  logic [AXIS_W-1:0] semi_b_i,
  input  logic              out_full_i,
  output logic              adv_o,
  output logic              out_valid_o,
  output q_item_t           out_item_o
);

  // entry and multiply stages
  logic              v0_q, v1_q, v2_q;
  logic [AXIS_W-1:0] x0_q, x1_q, x2_q;
  logic [SQ_W-1:0]   aa1_q, xx1_q, bb1_q;
  logic [PROD_W-1:0] prod2_q;

  // square root stages
  logic              sv_q [0:ROOT_W];
  logic [AXIS_W-1:0] sx_q [0:ROOT_W];
  logic [RAD_W-1:0]  sn_q [0:ROOT_W];
  logic [REM_W-1:0]  sr_q [0:ROOT_W];
  logic [ROOT_W-1:0] sq_q [0:ROOT_W];
  logic [REM_W-1:0]  sr_d [1:ROOT_W];
  logic [ROOT_W-1:0] sq_d [1:ROOT_W];
  logic [REM_W+1:0]  s_tmp [0:ROOT_W-1];
  logic [REM_W+1:0]  s_try [0:ROOT_W-1];

  // division stages
  logic              dv_q [0:Y_W];
  logic [AXIS_W-1:0] dx_q [0:Y_W];
  logic [Y_W-1:0]    dn_q [0:Y_W];
  logic [AXIS_W-1:0] dr_q [0:Y_W];
  logic [Y_W-1:0]    dq_q [0:Y_W];
  logic [AXIS_W-1:0] dr_d [1:Y_W];
  logic [Y_W-1:0]    dq_d [1:Y_W];
  logic [AXIS_W:0]   d_tmp [0:Y_W-1];

  logic [AXIS_W-1:0] x_sat;

  // whole pipeline moves unless the finished item cannot enter the queue
  assign adv_o = !(dv_q[Y_W] && out_full_i);
  assign x_sat = (in_x_i > semi_a_i) ? semi_a_i : in_x_i;

  // one restoring square root step per stage
  always_comb begin
    for (int k = 0; k < ROOT_W; k++) begin
      s_tmp[k] = {sr_q[k], sn_q[k][RAD_W-1 -: 2]};
      s_try[k] = {2'b00, sq_q[k], 2'b01};
      if (s_tmp[k] >= s_try[k]) begin
        sr_d[k+1] = REM_W'(s_tmp[k] - s_try[k]);
        sq_d[k+1] = {sq_q[k][ROOT_W-2:0], 1'b1};
      end else begin
        sr_d[k+1] = REM_W'(s_tmp[k]);
        sq_d[k+1] = {sq_q[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // one restoring division step per stage
  always_comb begin
    for (int k = 0; k < Y_W; k++) begin
      d_tmp[k] = {dr_q[k], dn_q[k][Y_W-1]};
      if (d_tmp[k] >= {1'b0, semi_a_i}) begin
        dr_d[k+1] = AXIS_W'(d_tmp[k] - {1'b0, semi_a_i});
        dq_d[k+1] = {dq_q[k][Y_W-2:0], 1'b1};
      end else begin
        dr_d[k+1] = AXIS_W'(d_tmp[k]);
        dq_d[k+1] = {dq_q[k][Y_W-2:0], 1'b0};
      end
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 0; k <= ROOT_W; k++) sv_q[k] <= 1'b0;
      for (int k = 0; k <= Y_W; k++) dv_q[k] <= 1'b0;
    end else if (adv_o) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q;
      sv_q[0] <= v2_q;
      for (int k = 1; k <= ROOT_W; k++) sv_q[k] <= sv_q[k-1];
      dv_q[0] <= sv_q[ROOT_W];
      for (int k = 1; k <= Y_W; k++) dv_q[k] <= dv_q[k-1];
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      x0_q    <= x_sat;
      x1_q    <= x0_q;
      aa1_q   <= SQ_W'(semi_a_i) * SQ_W'(semi_a_i);
      xx1_q   <= SQ_W'(x0_q) * SQ_W'(x0_q);
      bb1_q   <= SQ_W'(semi_b_i) * SQ_W'(semi_b_i);
      x2_q    <= x1_q;
      prod2_q <= PROD_W'(bb1_q) * PROD_W'(aa1_q - xx1_q);
      sx_q[0] <= x2_q;
      sn_q[0] <= {prod2_q, {(2*FRAC_W){1'b0}}};
      sr_q[0] <= '0;
      sq_q[0] <= '0;
      for (int k = 1; k <= ROOT_W; k++) begin
        sx_q[k] <= sx_q[k-1];
        sn_q[k] <= {sn_q[k-1][RAD_W-3:0], 2'b00};
        sr_q[k] <= sr_d[k];
        sq_q[k] <= sq_d[k];
      end
      dx_q[0] <= sx_q[ROOT_W];
      dr_q[0] <= sq_q[ROOT_W][ROOT_W-1 -: AXIS_W];
      dn_q[0] <= sq_q[ROOT_W][Y_W-1:0];
      dq_q[0] <= '0;
      for (int k = 1; k <= Y_W; k++) begin
        dx_q[k] <= dx_q[k-1];
        dn_q[k] <= {dn_q[k-1][Y_W-2:0], 1'b0};
        dr_q[k] <= dr_d[k];
        dq_q[k] <= dq_d[k];
      end
    end
  end

  assign out_valid_o  = dv_q[Y_W];
  assign out_item_o.x = dx_q[Y_W];
  // zero semi-axis: all points at the center
  assign out_item_o.y = (semi_a_i == '0) ? '0 : dq_q[Y_W];

endmodule

FILE: src/elop_queue.sv
// Short queue of computed offsets between front and back.
module elop_queue import elop_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t data_o
);

  q_item_t           mem_q [0:Q_DEPTH-1];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(Q_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= data_i;
  end

endmodule

FILE: src/elop_back.sv
// Back: expands one offset into its four mirrored ring points.
module elop_back import elop_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     q_valid_i,
  input  q_item_t                  q_item_i,
  output logic                     q_pop_o,
  input  logic [AXIS_W-1:0]        semi_a_i,
  input  logic signed [CTR_W-1:0]  center_x_i,
  input  logic signed [CTR_W-1:0]  center_y_i,
  input  logic                     pop,
  output logic                     empty,
  output logic [IDX_W-1:0]         point_index_o,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic                     last_o
);

  phase_e  phase_q, phase_d;
  logic    busy_q, busy_d;
  q_item_t cur_q;
  logic    take, load;

  logic [IDX_W-1:0]          a_ext, a1, xi, lo_idx;
  logic signed [CTR_W:0]     sx_pos, sx_neg;
  logic signed [COORD_W-1:0] cy_fx, y_fx;

  assign take    = busy_q && pop;
  assign load    = q_valid_i && (!busy_q || (take && phase_q == PH_UL));
  assign q_pop_o = load;

  // next state
  always_comb begin
    phase_d = phase_q;
    busy_d  = busy_q;
    if (take) begin
      case (phase_q)
        PH_UR:   phase_d = PH_LR;
        PH_LR:   phase_d = PH_LL;
        PH_LL:   phase_d = PH_UL;
        PH_UL:   begin
          phase_d = PH_UR;
          busy_d  = 1'b0;
        end
        default: phase_d = PH_UR;
      endcase
    end
    if (load) begin
      phase_d = PH_UR;
      busy_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_UR;
      busy_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) cur_q <= q_item_i;
  end

  // shared point arithmetic
  assign a_ext  = IDX_W'(semi_a_i);
  assign a1     = a_ext + 1'b1;
  assign xi     = IDX_W'(cur_q.x);
  assign lo_idx = a_ext - xi;
  assign sx_pos = (CTR_W+1)'(center_x_i) + $signed({1'b0, (CTR_W)'(cur_q.x)});
  assign sx_neg = (CTR_W+1)'(center_x_i) - $signed({1'b0, (CTR_W)'(cur_q.x)});
  assign cy_fx  = COORD_W'(center_y_i) <<< FRAC_W;
  assign y_fx   = $signed(COORD_W'(cur_q.y));

  // outputs per quadrant
  always_comb begin
    empty  = !busy_q;
    last_o = 1'b0;
    case (phase_q)
      PH_UR: begin
        point_index_o = xi;
        point_x_o     = COORD_W'(sx_pos) <<< FRAC_W;
        point_y_o     = cy_fx - y_fx;
      end
      PH_LR: begin
        point_index_o = a1 + lo_idx;
        point_x_o     = COORD_W'(sx_pos) <<< FRAC_W;
        point_y_o     = cy_fx + y_fx;
      end
      PH_LL: begin
        point_index_o = (a1 << 1) + xi;
        point_x_o     = COORD_W'(sx_neg) <<< FRAC_W;
        point_y_o     = cy_fx + y_fx;
      end
      PH_UL: begin
        point_index_o = (a1 << 1) + a1 + lo_idx;
        point_x_o     = COORD_W'(sx_neg) <<< FRAC_W;
        point_y_o     = cy_fx - y_fx;
        last_o        = 1'b1;
      end
      default: begin
        point_index_o = '0;
        point_x_o     = '0;
        point_y_o     = '0;
      end
    endcase
  end

endmodule

FILE: src/ellipse_outline_points_core.sv
// Ellipse outline point generator: four ring points per horizontal offset.
// Pipeline: three entry/multiply stages, 29 square root stages and 19 division
//   stages, then the queue and the back.
// One port gives four points per offset; the next offset can load as the last is taken.
// Reset: queue, pipeline valid bits and expander clear; axes reset to 1, center to 0.
module ellipse_outline_points_core import elop_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [AXIS_W-1:0]         x_offset_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [IDX_W-1:0]          point_index_o,
  output logic signed [COORD_W-1:0] point_x_o,
  output logic signed [COORD_W-1:0] point_y_o,
  output logic                      last_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CTR_W-1:0]          cfg_data_i
);

  logic [AXIS_W-1:0]       axis_first_q, axis_second_q, semi_a, semi_b;
  logic signed [CTR_W-1:0] center_x_q, center_y_q;
  logic                    adv, f_valid, q_full, q_valid, q_pop;
  q_item_t                 f_item, q_item;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_first_q  <= AXIS_W'(1);
      axis_second_q <= AXIS_W'(1);
      center_x_q    <= '0;
      center_y_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AXIS_FIRST:  axis_first_q  <= cfg_data_i[AXIS_W-1:0];
        CFG_AXIS_SECOND: axis_second_q <= cfg_data_i[AXIS_W-1:0];
        CFG_CENTER_X:    center_x_q    <= $signed(cfg_data_i);
        CFG_CENTER_Y:    center_y_q    <= $signed(cfg_data_i);
        default:         ;
      endcase
    end
  end

  // larger axis is a, smaller is b
  assign semi_a = (axis_first_q > axis_second_q) ? axis_first_q : axis_second_q;
  assign semi_b = (axis_first_q > axis_second_q) ? axis_second_q : axis_first_q;
  assign full   = !adv;

  elop_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (push),
    .in_x_i      (x_offset_i),
    .semi_a_i    (semi_a),
    .semi_b_i    (semi_b),
    .out_full_i  (q_full),
    .adv_o       (adv),
    .out_valid_o (f_valid),
    .out_item_o  (f_item)
  );

  elop_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid),
    .data_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  elop_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .q_pop_o       (q_pop),
    .semi_a_i      (semi_a),
    .center_x_i    (center_x_q),
    .center_y_i    (center_y_q),
    .pop           (pop),
    .empty         (empty),
    .point_index_o (point_index_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_o        (last_o)
  );

  // a taken point that is not the last is always followed by another
  a_point_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && pop && !last_o |=> !empty)
    else $error("point run broken before last point");

  // results run dry only right after a last point was taken
  a_dry_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty) |-> $past(last_o) && $past(pop))
    else $error("result stream ended mid-offset");

  // the front stalls only when its finished item meets a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> f_valid && q_full)
    else $error("front stalled without cause");

endmodule
